// File: rtl/dlq_pkg.sv
// Shared types and codes for the delta-list sleep timer queue.
package dlq_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DELETED  = 3'd1;
    localparam logic [2:0] ST_WOKEN    = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_ZERO     = 3'd5;
    localparam logic [2:0] ST_INACTIVE = 3'd6;

    // Operation of the shared tick arithmetic unit.
    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        alu_op_t op;
    } alu_ctl_t;

endpackage

// File: rtl/dlq_alu.sv
// Shared tick adder/subtractor with borrow used by every queue operation.
module dlq_alu #(
    parameter int TICK_BITS = 16
) (
    input  dlq_pkg::alu_ctl_t      ctl,
    input  logic [TICK_BITS-1:0]   a,
    input  logic [TICK_BITS-1:0]   b,
    output logic [TICK_BITS-1:0]   res,
    output logic                   borrow
);

    logic                 is_sub;
    logic [TICK_BITS-1:0] b_eff;
    logic                 carry;

    // One carry chain: a - b is a + ~b + 1, and borrow is the missing carry.
    assign is_sub = (ctl.op == dlq_pkg::ALU_SUB);
    assign b_eff  = is_sub ? ~b : b;
    assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {{TICK_BITS{1'b0}}, is_sub};
    assign borrow = is_sub & ~carry;

endmodule

// File: rtl/delta_list_sleep_timer_queue.sv
// Top level of the delta-list sleep timer queue with its sequencer and storage.
//
// Usage: words enter on the s_ channel (op, proc_id, ticks, handle) and results
// leave on the m_ channel (status, handle_res, woken_proc, last). Each input
// word yields one result, except a tick that wakes timers, which yields one
// result per timer it wakes; last marks the final result of the word. Op 3 is
// dropped silently. One word is processed at a time; s_ready is high only
// while the sequencer is idle. A small sequencer steps one queue entry at a
// time through simple dual-port memories with registered reads and one
// shared adder. An add scans for the lowest free slot, walks the queue and
// moves later entries back; a delete finds the timer, hands its delta to
// the next timer and closes the gap; a tick lowers the head and pops each
// timer that reaches zero.
// Results go out through a single output register. When the receiver stalls,
// the sequencer waits at its next result until that register is free.
// Reset clears the slot-active bits, the queue count and all control state;
// the memories are not cleared and need no sweep.
module delta_list_sleep_timer_queue #(
    parameter int DEPTH     = 16,
    parameter int TICK_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_proc_id,
    input  logic [15:0] s_ticks,
    input  logic [3:0]  s_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_handle_res,
    output logic [7:0]  m_woken_proc,
    output logic        m_last
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [22:0] {
        S_IDLE   = 23'h000001,
        S_FIND   = 23'h000002,
        S_W_ORD  = 23'h000004,
        S_W_DEL  = 23'h000008,
        S_W_CMP  = 23'h000010,
        S_W_INS  = 23'h000020,
        S_SH_RD  = 23'h000040,
        S_SH_WR  = 23'h000080,
        S_D_RD   = 23'h000100,
        S_D_CMP  = 23'h000200,
        S_D_NX   = 23'h000400,
        S_D_NXD  = 23'h000800,
        S_D_HD   = 23'h001000,
        S_D_SUM  = 23'h002000,
        S_D_FIN  = 23'h004000,
        S_RM_CHK = 23'h008000,
        S_RM_WR  = 23'h010000,
        S_T_ORD  = 23'h020000,
        S_T_DEL  = 23'h040000,
        S_T_CHK  = 23'h080000,
        S_T_POP  = 23'h100000,
        S_T_NEXT = 23'h200000,
        S_EMIT   = 23'h400000
    } state_t;

    state_t state_reg;
    state_t after_reg;

    // Storage: queue order, per-slot delta and per-slot process id.
    logic [SLOT_W-1:0]    order_mem [DEPTH];
    logic [TICK_BITS-1:0] delta_mem [DEPTH];
    logic [7:0]           proc_mem  [DEPTH];

    logic [SLOT_W-1:0]    order_rd_reg;
    logic [TICK_BITS-1:0] delta_rd_reg;
    logic [7:0]           proc_rd_reg;

    logic [DEPTH-1:0]     active_reg;
    logic [CNT_W-1:0]     count_reg;

    // Working registers of the current word.
    logic [TICK_BITS-1:0] ticks_reg;
    logic [TICK_BITS-1:0] d_reg;
    logic [7:0]           proc_reg;
    logic [3:0]           handle_reg;
    logic [SLOT_W-1:0]    hslot_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    cur_slot_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     i_reg;
    logic                 first_reg;
    logic                 pending_reg;
    logic [SLOT_W-1:0]    pend_slot_reg;
    logic [7:0]           pend_proc_reg;

    // Staged result and the output register.
    logic [2:0]           res_status_reg;
    logic [3:0]           res_handle_reg;
    logic [7:0]           res_proc_reg;
    logic                 res_last_reg;
    logic                 m_valid_reg;
    logic [2:0]           m_status_reg;
    logic [3:0]           m_handle_reg;
    logic [7:0]           m_proc_reg;
    logic                 m_last_reg;

    // Memory port signals.
    logic                 order_we;
    logic [SLOT_W-1:0]    order_wa;
    logic [SLOT_W-1:0]    order_wd;
    logic [SLOT_W-1:0]    order_ra;
    logic                 delta_we;
    logic [SLOT_W-1:0]    delta_wa;
    logic [TICK_BITS-1:0] delta_wd;
    logic [SLOT_W-1:0]    delta_ra;
    logic                 proc_we;

    // Shared arithmetic unit.
    dlq_pkg::alu_ctl_t    alu_ctl;
    logic [TICK_BITS-1:0] alu_a;
    logic [TICK_BITS-1:0] alu_b;
    logic [TICK_BITS-1:0] alu_res;
    logic                 alu_borrow;

    logic                 accept;
    logic                 out_free;
    logic [TICK_BITS-1:0] in_ticks;
    logic [SLOT_W-1:0]    in_hslot;
    logic                 in_handle_ok;
    logic [CNT_W-1:0]     pos_inc;
    logic [CNT_W-1:0]     i_inc;
    logic                 tick_zero;

    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign in_ticks     = TICK_BITS'(s_ticks);
    assign in_hslot     = SLOT_W'(s_handle);
    assign in_handle_ok = (32'(s_handle) < DEPTH) && active_reg[in_hslot];
    assign pos_inc      = pos_reg + CNT_W'(1);
    assign i_inc        = i_reg + CNT_W'(1);

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_handle_res = m_handle_reg;
    assign m_woken_proc = m_proc_reg;
    assign m_last       = m_last_reg;

    dlq_alu #(
        .TICK_BITS (TICK_BITS)
    ) u_alu (
        .ctl    (alu_ctl),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    // Operand selection for the shared unit.
    always_comb begin
        alu_ctl.op = dlq_pkg::ALU_SUB;
        alu_a      = ticks_reg;
        alu_b      = delta_rd_reg;
        case (state_reg)
            S_W_INS: begin
                alu_a = d_reg;
                alu_b = ticks_reg;
            end
            S_D_SUM: begin
                alu_ctl.op = dlq_pkg::ALU_ADD;
                alu_a      = delta_rd_reg;
                alu_b      = d_reg;
            end
            S_T_CHK: begin
                alu_a = delta_rd_reg;
                alu_b = TICK_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    // A head whose delta reaches zero after this tick expires.
    assign tick_zero = first_reg ? (alu_borrow || (alu_res == '0))
                                 : (delta_rd_reg == '0);

    // Memory addresses and write ports per sequencer step.
    always_comb begin
        order_we = 1'b0;
        order_wa = i_reg[SLOT_W-1:0];
        order_wd = order_rd_reg;
        order_ra = pos_reg[SLOT_W-1:0];
        delta_we = 1'b0;
        delta_wa = cur_slot_reg;
        delta_wd = alu_res;
        delta_ra = order_rd_reg;
        proc_we  = 1'b0;
        case (state_reg)
            S_SH_RD: begin
                if (i_reg == pos_reg) begin
                    order_we = 1'b1;
                    order_wa = pos_reg[SLOT_W-1:0];
                    order_wd = slot_reg;
                    delta_we = 1'b1;
                    delta_wa = slot_reg;
                    delta_wd = ticks_reg;
                    proc_we  = 1'b1;
                end
                order_ra = SLOT_W'(i_reg - CNT_W'(1));
            end
            S_SH_WR, S_RM_WR: begin
                order_we = 1'b1;
            end
            S_W_INS, S_D_SUM: begin
                delta_we = 1'b1;
            end
            S_T_CHK: begin
                delta_we = first_reg && !alu_borrow;
            end
            S_D_NX: begin
                order_ra = pos_inc[SLOT_W-1:0];
            end
            S_D_NXD: begin
                delta_ra = hslot_reg;
            end
            S_D_HD: begin
                delta_ra = cur_slot_reg;
            end
            S_RM_CHK: begin
                order_ra = i_inc[SLOT_W-1:0];
            end
            S_T_ORD: begin
                order_ra = '0;
            end
            default: begin
            end
        endcase
    end

    // Order memory.
    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_wa] <= order_wd;
        end
        order_rd_reg <= order_mem[order_ra];
    end

    // Delta memory.
    always_ff @(posedge aclk) begin
        if (delta_we) begin
            delta_mem[delta_wa] <= delta_wd;
        end
        delta_rd_reg <= delta_mem[delta_ra];
    end

    // Process id memory, read alongside the delta.
    always_ff @(posedge aclk) begin
        if (proc_we) begin
            proc_mem[slot_reg] <= proc_reg;
        end
        proc_rd_reg <= proc_mem[delta_ra];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            m_status_reg <= res_status_reg;
            m_handle_reg <= res_handle_reg;
            m_proc_reg   <= res_proc_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            after_reg   <= S_IDLE;
            active_reg  <= '0;
            count_reg   <= '0;
            first_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        proc_reg       <= s_proc_id;
                        ticks_reg      <= in_ticks;
                        handle_reg     <= s_handle;
                        hslot_reg      <= in_hslot;
                        idx_reg        <= '0;
                        pos_reg        <= '0;
                        first_reg      <= 1'b1;
                        pending_reg    <= 1'b0;
                        res_handle_reg <= '0;
                        res_proc_reg   <= '0;
                        res_last_reg   <= 1'b1;
                        after_reg      <= S_IDLE;
                        case (s_op)
                            dlq_pkg::OP_ADD: begin
                                if (in_ticks == '0) begin
                                    res_status_reg <= dlq_pkg::ST_ZERO;
                                    state_reg      <= S_EMIT;
                                end else if (count_reg == CNT_W'(DEPTH)) begin
                                    res_status_reg <= dlq_pkg::ST_FULL;
                                    state_reg      <= S_EMIT;
                                end else begin
                                    state_reg <= S_FIND;
                                end
                            end
                            dlq_pkg::OP_DEL: begin
                                if (!in_handle_ok) begin
                                    res_status_reg <= dlq_pkg::ST_INACTIVE;
                                    res_handle_reg <= s_handle;
                                    state_reg      <= S_EMIT;
                                end else if (count_reg == '0) begin
                                    state_reg <= S_D_FIN;
                                end else begin
                                    state_reg <= S_D_RD;
                                end
                            end
                            dlq_pkg::OP_TICK: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= dlq_pkg::ST_NONE;
                                    state_reg      <= S_EMIT;
                                end else begin
                                    state_reg <= S_T_ORD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // Scan for the lowest free slot, one per cycle.
                S_FIND: begin
                    if (!active_reg[idx_reg]) begin
                        slot_reg <= idx_reg;
                        if (count_reg == '0) begin
                            i_reg     <= count_reg;
                            state_reg <= S_SH_RD;
                        end else begin
                            state_reg <= S_W_ORD;
                        end
                    end else begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end

                // Walk the queue, taking each earlier delta off the new timer.
                S_W_ORD: begin
                    state_reg <= S_W_DEL;
                end
                S_W_DEL: begin
                    cur_slot_reg <= order_rd_reg;
                    state_reg    <= S_W_CMP;
                end
                S_W_CMP: begin
                    d_reg <= delta_rd_reg;
                    if (alu_borrow) begin
                        state_reg <= S_W_INS;
                    end else begin
                        ticks_reg <= alu_res;
                        pos_reg   <= pos_inc;
                        if (pos_inc == count_reg) begin
                            i_reg     <= count_reg;
                            state_reg <= S_SH_RD;
                        end else begin
                            state_reg <= S_W_ORD;
                        end
                    end
                end
                S_W_INS: begin
                    i_reg     <= count_reg;
                    state_reg <= S_SH_RD;
                end

                // Move later entries back one place, then insert.
                S_SH_RD: begin
                    if (i_reg == pos_reg) begin
                        active_reg[slot_reg] <= 1'b1;
                        count_reg            <= count_reg + CNT_W'(1);
                        res_status_reg       <= dlq_pkg::ST_ADDED;
                        res_handle_reg       <= 4'(slot_reg);
                        after_reg            <= S_IDLE;
                        state_reg            <= S_EMIT;
                    end else begin
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    i_reg     <= i_reg - CNT_W'(1);
                    state_reg <= S_SH_RD;
                end

                // Search for the timer being deleted.
                S_D_RD: begin
                    state_reg <= S_D_CMP;
                end
                S_D_CMP: begin
                    if (order_rd_reg == hslot_reg) begin
                        if (pos_inc < count_reg) begin
                            state_reg <= S_D_NX;
                        end else begin
                            i_reg     <= pos_reg;
                            after_reg <= S_D_FIN;
                            state_reg <= S_RM_CHK;
                        end
                    end else begin
                        pos_reg <= pos_inc;
                        if (pos_inc == count_reg) begin
                            state_reg <= S_D_FIN;
                        end else begin
                            state_reg <= S_D_RD;
                        end
                    end
                end

                // Hand the deleted delta to the next timer.
                S_D_NX: begin
                    state_reg <= S_D_NXD;
                end
                S_D_NXD: begin
                    cur_slot_reg <= order_rd_reg;
                    state_reg    <= S_D_HD;
                end
                S_D_HD: begin
                    d_reg     <= delta_rd_reg;
                    state_reg <= S_D_SUM;
                end
                S_D_SUM: begin
                    i_reg     <= pos_reg;
                    after_reg <= S_D_FIN;
                    state_reg <= S_RM_CHK;
                end
                S_D_FIN: begin
                    active_reg[hslot_reg] <= 1'b0;
                    res_status_reg        <= dlq_pkg::ST_DELETED;
                    res_handle_reg        <= handle_reg;
                    after_reg             <= S_IDLE;
                    state_reg             <= S_EMIT;
                end

                // Close the gap at position i, moving each later entry forward one place.
                S_RM_CHK: begin
                    if (i_inc < count_reg) begin
                        state_reg <= S_RM_WR;
                    end else begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= after_reg;
                    end
                end
                S_RM_WR: begin
                    i_reg     <= i_inc;
                    state_reg <= S_RM_CHK;
                end

                // Tick: lower the head once, then pop heads at zero.
                S_T_ORD: begin
                    state_reg <= S_T_DEL;
                end
                S_T_DEL: begin
                    cur_slot_reg <= order_rd_reg;
                    state_reg    <= S_T_CHK;
                end
                S_T_CHK: begin
                    first_reg <= 1'b0;
                    if (tick_zero) begin
                        pend_slot_reg <= cur_slot_reg;
                        pend_proc_reg <= proc_rd_reg;
                        pending_reg   <= 1'b1;
                    end
                    if (pending_reg) begin
                        res_status_reg <= dlq_pkg::ST_WOKEN;
                        res_handle_reg <= 4'(pend_slot_reg);
                        res_proc_reg   <= pend_proc_reg;
                        res_last_reg   <= !tick_zero;
                        after_reg      <= tick_zero ? S_T_POP : S_IDLE;
                        state_reg      <= S_EMIT;
                    end else if (tick_zero) begin
                        state_reg <= S_T_POP;
                    end else begin
                        res_status_reg <= dlq_pkg::ST_NONE;
                        res_last_reg   <= 1'b1;
                        after_reg      <= S_IDLE;
                        state_reg      <= S_EMIT;
                    end
                end
                S_T_POP: begin
                    active_reg[pend_slot_reg] <= 1'b0;
                    i_reg                     <= '0;
                    after_reg                 <= S_T_NEXT;
                    state_reg                 <= S_RM_CHK;
                end
                S_T_NEXT: begin
                    if (count_reg == '0) begin
                        res_status_reg <= dlq_pkg::ST_WOKEN;
                        res_handle_reg <= 4'(pend_slot_reg);
                        res_proc_reg   <= pend_proc_reg;
                        res_last_reg   <= 1'b1;
                        after_reg      <= S_IDLE;
                        state_reg      <= S_EMIT;
                    end else begin
                        state_reg <= S_T_ORD;
                    end
                end

                // Hand the staged result to the output register.
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= after_reg;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
